[hw/rtl/rlfs_pkg.sv]
`default_nettype none

package rlfs_pkg;

  // Configuration register indexes.
  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_TIMEOUT_RELOAD = 3'd0;
  localparam reg_index_t REG_POOR_THRESHOLD = 3'd1;
  localparam reg_index_t REG_GOOD_THRESHOLD = 3'd2;
  localparam reg_index_t REG_SWITCH_RUN     = 3'd3;
  localparam reg_index_t REG_BEEP_PERIOD    = 3'd4;

  // Register values after reset.
  localparam logic [7:0] TIMEOUT_RELOAD_RST = 8'd25;
  localparam logic [3:0] POOR_THRESHOLD_RST = 4'd10;
  localparam logic [3:0] GOOD_THRESHOLD_RST = 4'd12;
  localparam logic [7:0] SWITCH_RUN_RST     = 8'd10;
  localparam logic [7:0] BEEP_PERIOD_RST    = 8'd20;

  // Item kinds.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Bit positions in the lamp register.
  localparam int LAMP_WHITE = 0;
  localparam int LAMP_BLUE  = 1;
  localparam int LAMP_RED   = 2;

  // Heartbeat text "RSSI=".
  localparam logic [2:0] HB_LEN = 3'd5;

  function automatic logic [7:0] hb_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h52;  // 'R'
      3'd1:    ch = 8'h53;  // 'S'
      3'd2:    ch = 8'h53;  // 'S'
      3'd3:    ch = 8'h49;  // 'I'
      3'd4:    ch = 8'h3D;  // '='
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/radio_link_failover_supervisor.sv]
// Radio link failover supervisor. Each item is a received link byte or a timer
// tick and yields exactly one result item. The block takes one item per clock
// cycle while the output is not stalled. Items pass through an input register, a
// single pass of compare and counter logic that updates the supervisor state, and
// a result register; the state update for one item is done within that pass, so
// the next item follows directly. Configuration is written through cfg_write,
// cfg_index and cfg_data.
`default_nettype none

module radio_link_failover_supervisor (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] rx_byte,
  input  wire logic [3:0] link_quality,
  // Output channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            heartbeat_seen,
  output logic            link_up,
  output logic            backup_selected,
  output logic            lamp_white,
  output logic            lamp_blue,
  output logic            lamp_red,
  output logic            beep,
  // Configuration write port.
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  // Configuration registers.
  logic [7:0] timeout_reload;
  logic [3:0] poor_threshold;
  logic [3:0] good_threshold;
  logic [7:0] switch_run;
  logic [7:0] beep_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reload <= rlfs_pkg::TIMEOUT_RELOAD_RST;
      poor_threshold <= rlfs_pkg::POOR_THRESHOLD_RST;
      good_threshold <= rlfs_pkg::GOOD_THRESHOLD_RST;
      switch_run     <= rlfs_pkg::SWITCH_RUN_RST;
      beep_period    <= rlfs_pkg::BEEP_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rlfs_pkg::REG_TIMEOUT_RELOAD: timeout_reload <= cfg_data;
        rlfs_pkg::REG_POOR_THRESHOLD: poor_threshold <= cfg_data[3:0];
        rlfs_pkg::REG_GOOD_THRESHOLD: good_threshold <= cfg_data[3:0];
        rlfs_pkg::REG_SWITCH_RUN:     switch_run     <= cfg_data;
        rlfs_pkg::REG_BEEP_PERIOD:    beep_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_byte;
  logic [3:0] s1_quality;
  logic       s1_advance;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode  <= opcode;
      s1_byte    <= rx_byte;
      s1_quality <= link_quality;
    end
  end

  // Supervisor state.
  logic [2:0] match_pos;
  logic [7:0] timeout_left;
  logic       is_connected;
  logic       ever_connected;
  logic [7:0] poor_run;
  logic [7:0] good_run;
  logic       radio_sel;
  logic [7:0] beep_count;
  logic [2:0] lamp_bits;

  logic [2:0] match_pos_next;
  logic [7:0] timeout_left_next;
  logic       is_connected_next;
  logic       ever_connected_next;
  logic [7:0] poor_run_next;
  logic [7:0] good_run_next;
  logic       radio_sel_next;
  logic [7:0] beep_count_next;
  logic [2:0] lamp_bits_next;
  logic       seen_next;
  logic       beep_next;

  // Next state for the item in the input register.
  always_comb begin
    logic       sel_mid;
    logic [7:0] beep_inc;
    match_pos_next      = match_pos;
    timeout_left_next   = timeout_left;
    is_connected_next   = is_connected;
    ever_connected_next = ever_connected;
    poor_run_next       = poor_run;
    good_run_next       = good_run;
    radio_sel_next      = radio_sel;
    beep_count_next     = beep_count;
    lamp_bits_next      = lamp_bits;
    seen_next           = 1'b0;
    beep_next           = 1'b0;
    sel_mid             = radio_sel;
    beep_inc            = beep_count + 8'd1;

    if (s1_opcode == rlfs_pkg::OP_BYTE) begin
      // Heartbeat matcher; a mismatching byte restarts the match.
      if (match_pos < rlfs_pkg::HB_LEN && s1_byte == rlfs_pkg::hb_char(match_pos)) begin
        if (match_pos == rlfs_pkg::HB_LEN - 3'd1) begin
          match_pos_next      = 3'd0;
          timeout_left_next   = timeout_reload;
          is_connected_next   = 1'b1;
          ever_connected_next = 1'b1;
          lamp_bits_next[rlfs_pkg::LAMP_WHITE] = 1'b1;
          seen_next           = 1'b1;
        end else begin
          match_pos_next = match_pos + 3'd1;
        end
      end else begin
        match_pos_next = 3'd0;
      end
    end else begin
      // Activity lamp of the radio in use toggles, the other goes dark.
      if (!radio_sel) begin
        lamp_bits_next[rlfs_pkg::LAMP_BLUE] = !lamp_bits[rlfs_pkg::LAMP_BLUE];
        lamp_bits_next[rlfs_pkg::LAMP_RED]  = 1'b0;
      end else begin
        lamp_bits_next[rlfs_pkg::LAMP_BLUE] = 1'b0;
        lamp_bits_next[rlfs_pkg::LAMP_RED]  = !lamp_bits[rlfs_pkg::LAMP_RED];
      end

      // Link timeout.
      if (timeout_left != 8'd0) begin
        timeout_left_next = timeout_left - 8'd1;
      end else begin
        is_connected_next = 1'b0;
        lamp_bits_next[rlfs_pkg::LAMP_WHITE] = 1'b0;
      end

      // Quality run counters saturate at their top value.
      if (s1_quality < poor_threshold) begin
        poor_run_next = (poor_run == 8'hFF) ? poor_run : poor_run + 8'd1;
      end else begin
        poor_run_next = 8'd0;
      end
      if (s1_quality > good_threshold) begin
        good_run_next = (good_run == 8'hFF) ? good_run : good_run + 8'd1;
      end else begin
        good_run_next = 8'd0;
      end

      // Switch to backup first, then test the switch back on the new choice.
      if (!radio_sel && poor_run_next > switch_run && is_connected_next) begin
        sel_mid = 1'b1;
      end
      radio_sel_next = (sel_mid && good_run_next > switch_run) ? 1'b0 : sel_mid;

      // Beep pacing while the link is lost on the backup radio.
      if (!is_connected_next && ever_connected && radio_sel_next) begin
        if (beep_inc == beep_period) begin
          beep_next       = 1'b1;
          beep_count_next = 8'd0;
        end else begin
          beep_count_next = beep_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_pos      <= 3'd0;
      timeout_left   <= 8'd0;
      is_connected   <= 1'b0;
      ever_connected <= 1'b0;
      poor_run       <= 8'd0;
      good_run       <= 8'd0;
      radio_sel      <= 1'b0;
      beep_count     <= 8'd0;
      lamp_bits      <= 3'd0;
    end else if (s1_advance) begin
      match_pos      <= match_pos_next;
      timeout_left   <= timeout_left_next;
      is_connected   <= is_connected_next;
      ever_connected <= ever_connected_next;
      poor_run       <= poor_run_next;
      good_run       <= good_run_next;
      radio_sel      <= radio_sel_next;
      beep_count     <= beep_count_next;
      lamp_bits      <= lamp_bits_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      heartbeat_seen  <= seen_next;
      link_up         <= is_connected_next;
      backup_selected <= radio_sel_next;
      lamp_white      <= lamp_bits_next[rlfs_pkg::LAMP_WHITE];
      lamp_blue       <= lamp_bits_next[rlfs_pkg::LAMP_BLUE];
      lamp_red        <= lamp_bits_next[rlfs_pkg::LAMP_RED];
      beep            <= beep_next;
    end
  end

  // Checks on the supervisor logic.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_seen_beep_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(heartbeat_seen && beep))
    else $error("heartbeat and beep in the same result item");

  a_conn_implies_ever: assert property (@(posedge clk) disable iff (rst)
    is_connected |-> ever_connected)
    else $error("connected without ever having connected");

  a_lamps_excl: assert property (@(posedge clk) disable iff (rst)
    !(lamp_bits[rlfs_pkg::LAMP_BLUE] && lamp_bits[rlfs_pkg::LAMP_RED]))
    else $error("both radio lamps lit");

  a_match_range: assert property (@(posedge clk) disable iff (rst)
    match_pos < rlfs_pkg::HB_LEN)
    else $error("heartbeat match position out of range");

endmodule

`default_nettype wire

[sim/radio_link_failover_supervisor_checker.sv]
`timescale 1ns / 1ps

module radio_link_failover_supervisor_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  input  logic [3:0] link_quality,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       heartbeat_seen,
  input  logic       link_up,
  input  logic       backup_selected,
  input  logic       lamp_white,
  input  logic       lamp_blue,
  input  logic       lamp_red,
  input  logic       beep,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         pending
);

  // The heartbeat text, first character in the top byte.
  localparam logic [39:0] HEARTBEAT     = "RSSI=";
  localparam int          HEARTBEAT_LEN = 5;

  typedef struct packed {
    logic heartbeat_seen;
    logic link_up;
    logic backup_selected;
    logic lamp_white;
    logic lamp_blue;
    logic lamp_red;
    logic beep;
  } link_status_t;

  // Register copies.
  logic [7:0] timeout_reload;
  logic [3:0] poor_level;
  logic [3:0] good_level;
  logic [7:0] switch_len;
  logic [7:0] beep_gap;

  // Supervisor state as the block should hold it.
  logic [2:0] hb_pos;
  logic [7:0] ticks_left;
  logic       connected;
  logic       was_connected;
  logic [7:0] poor_streak;
  logic [7:0] good_streak;
  logic       on_backup;
  logic [7:0] beep_ctr;
  logic [2:0] lamps;

  link_status_t expected_status[$];

  // Advances the supervisor state by one item and returns the status it reports.
  task automatic predict_supervisor_status(input logic op, input logic [7:0] b,
                                           input logic [3:0] q,
                                           output link_status_t st);
    logic [2:0] pos;
    logic       seen;
    logic       buzz;
    seen = 1'b0;
    buzz = 1'b0;
    if (op == rlfs_pkg::OP_BYTE) begin
      // A mismatching byte is dropped and the match starts over at the beginning.
      pos = hb_pos;
      if (int'(pos) < HEARTBEAT_LEN && b == HEARTBEAT[39 - 8 * pos -: 8]) begin
        pos = pos + 3'd1;
        if (int'(pos) == HEARTBEAT_LEN) begin
          pos                         = 3'd0;
          ticks_left                  = timeout_reload;
          connected                   = 1'b1;
          was_connected               = 1'b1;
          lamps[rlfs_pkg::LAMP_WHITE] = 1'b1;
          seen                        = 1'b1;
        end
      end else begin
        pos = 3'd0;
      end
      hb_pos = pos;
    end else begin
      // The lamp of the radio in use toggles; the other one goes dark.
      if (!on_backup) begin
        lamps[rlfs_pkg::LAMP_BLUE] = ~lamps[rlfs_pkg::LAMP_BLUE];
        lamps[rlfs_pkg::LAMP_RED]  = 1'b0;
      end else begin
        lamps[rlfs_pkg::LAMP_BLUE] = 1'b0;
        lamps[rlfs_pkg::LAMP_RED]  = ~lamps[rlfs_pkg::LAMP_RED];
      end

      if (ticks_left != 8'd0) begin
        ticks_left = ticks_left - 8'd1;
      end else begin
        connected                   = 1'b0;
        lamps[rlfs_pkg::LAMP_WHITE] = 1'b0;
      end

      // Quality runs saturate at their top value.
      if (q < poor_level) begin
        poor_streak = (poor_streak == 8'hFF) ? poor_streak : poor_streak + 8'd1;
      end else begin
        poor_streak = 8'd0;
      end
      if (q > good_level) begin
        good_streak = (good_streak == 8'hFF) ? good_streak : good_streak + 8'd1;
      end else begin
        good_streak = 8'd0;
      end

      // The move to backup is decided first; the move back sees its outcome.
      if (!on_backup && poor_streak > switch_len && connected) begin
        on_backup = 1'b1;
      end
      if (on_backup && good_streak > switch_len) begin
        on_backup = 1'b0;
      end

      // The beep counter wraps and only runs while the link is lost on backup.
      if (!connected && was_connected && on_backup) begin
        beep_ctr = beep_ctr + 8'd1;
        if (beep_ctr == beep_gap) begin
          buzz     = 1'b1;
          beep_ctr = 8'd0;
        end
      end
    end

    st.heartbeat_seen  = seen;
    st.link_up         = connected;
    st.backup_selected = on_backup;
    st.lamp_white      = lamps[rlfs_pkg::LAMP_WHITE];
    st.lamp_blue       = lamps[rlfs_pkg::LAMP_BLUE];
    st.lamp_red        = lamps[rlfs_pkg::LAMP_RED];
    st.beep            = buzz;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port at each rising edge.
  always @(posedge clk) begin : watch
    link_status_t want;
    if (rst) begin
      timeout_reload = rlfs_pkg::TIMEOUT_RELOAD_RST;
      poor_level     = rlfs_pkg::POOR_THRESHOLD_RST;
      good_level     = rlfs_pkg::GOOD_THRESHOLD_RST;
      switch_len     = rlfs_pkg::SWITCH_RUN_RST;
      beep_gap       = rlfs_pkg::BEEP_PERIOD_RST;
      hb_pos         = 3'd0;
      ticks_left     = 8'd0;
      connected      = 1'b0;
      was_connected  = 1'b0;
      poor_streak    = 8'd0;
      good_streak    = 8'd0;
      on_backup      = 1'b0;
      beep_ctr       = 8'd0;
      lamps          = 3'd0;
      expected_status.delete();
    end else begin
      // Register writes; unknown indexes are ignored.
      if (cfg_write) begin
        case (cfg_index)
          rlfs_pkg::REG_TIMEOUT_RELOAD: timeout_reload = cfg_data;
          rlfs_pkg::REG_POOR_THRESHOLD: poor_level     = cfg_data[3:0];
          rlfs_pkg::REG_GOOD_THRESHOLD: good_level     = cfg_data[3:0];
          rlfs_pkg::REG_SWITCH_RUN:     switch_len     = cfg_data;
          rlfs_pkg::REG_BEEP_PERIOD:    beep_gap       = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        predict_supervisor_status(opcode, rx_byte, link_quality, want);
        expected_status.push_back(want);
      end

      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result item arrived with nothing expected");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("heartbeat_seen", want.heartbeat_seen, heartbeat_seen);
          check_field("link_up", want.link_up, link_up);
          check_field("backup_selected", want.backup_selected, backup_selected);
          check_field("lamp_white", want.lamp_white, lamp_white);
          check_field("lamp_blue", want.lamp_blue, lamp_blue);
          check_field("lamp_red", want.lamp_red, lamp_red);
          check_field("beep", want.beep, beep);
        end
      end
    end
    pending = expected_status.size();
  end

endmodule

[sim/radio_link_failover_supervisor_tb.sv]
`timescale 1ns / 1ps

module radio_link_failover_supervisor_tb;

  localparam logic [39:0] HEARTBEAT = "RSSI=";

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = rlfs_pkg::OP_BYTE;
  logic [7:0]           rx_byte = 8'd0;
  logic [3:0]           link_quality = 4'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 heartbeat_seen;
  logic                 link_up;
  logic                 backup_selected;
  logic                 lamp_white;
  logic                 lamp_blue;
  logic                 lamp_red;
  logic                 beep;
  logic                 cfg_write = 1'b0;
  rlfs_pkg::reg_index_t cfg_index = rlfs_pkg::REG_TIMEOUT_RELOAD;
  logic [7:0]           cfg_data = 8'd0;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;

  radio_link_failover_supervisor i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .rx_byte         (rx_byte),
    .link_quality    (link_quality),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .heartbeat_seen  (heartbeat_seen),
    .link_up         (link_up),
    .backup_selected (backup_selected),
    .lamp_white      (lamp_white),
    .lamp_blue       (lamp_blue),
    .lamp_red        (lamp_red),
    .beep            (beep),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  radio_link_failover_supervisor_checker i_chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .rx_byte         (rx_byte),
    .link_quality    (link_quality),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .heartbeat_seen  (heartbeat_seen),
    .link_up         (link_up),
    .backup_selected (backup_selected),
    .lamp_white      (lamp_white),
    .lamp_blue       (lamp_blue),
    .lamp_red        (lamp_red),
    .beep            (beep),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The result side stalls at random at the rate the current phase sets.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offers one item after a random gap and holds it until it is taken.
  task automatic put_item(input logic op, input logic [7:0] b, input logic [3:0] q);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    opcode       = op;
    rx_byte      = b;
    link_quality = q;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends the heartbeat text; a position in range gets a random byte instead.
  task automatic send_heartbeat(input int bad_at);
    logic [7:0] ch;
    for (int p = 0; p < 5; p++) begin
      ch = HEARTBEAT[39 - 8 * p -: 8];
      if (p == bad_at) begin
        ch = 8'($urandom);
      end
      put_item(rlfs_pkg::OP_BYTE, ch, 4'($urandom));
    end
  endtask

  // Stops offering items until every result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Register writes happen only once the block has gone quiet.
  task automatic write_reg(input rlfs_pkg::reg_index_t idx, input logic [7:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] reload, input logic [7:0] poor,
                            input logic [7:0] good, input logic [7:0] run,
                            input logic [7:0] period);
    drain();
    repeat (4) @(negedge clk);
    write_reg(rlfs_pkg::REG_TIMEOUT_RELOAD, reload);
    write_reg(rlfs_pkg::REG_POOR_THRESHOLD, poor);
    write_reg(rlfs_pkg::REG_GOOD_THRESHOLD, good);
    write_reg(rlfs_pkg::REG_SWITCH_RUN, run);
    write_reg(rlfs_pkg::REG_BEEP_PERIOD, period);
  endtask

  // Random traffic built from heartbeats, quality runs and line noise.
  task automatic random_traffic(input int count);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_heartbeat(($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 4)) : -1);
        sent += 5;
      end else if (pick < 50) begin
        len = $urandom_range(1, 12);
        repeat (len) put_item(rlfs_pkg::OP_TICK, 8'($urandom), 4'($urandom_range(0, 7)));
        sent += len;
      end else if (pick < 70) begin
        len = $urandom_range(1, 12);
        repeat (len) put_item(rlfs_pkg::OP_TICK, 8'($urandom), 4'($urandom_range(8, 15)));
        sent += len;
      end else if (pick < 88) begin
        len = $urandom_range(1, 6);
        repeat (len) put_item(rlfs_pkg::OP_TICK, 8'($urandom), 4'($urandom));
        sent += len;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          put_item(rlfs_pkg::OP_BYTE,
                   ($urandom_range(0, 2) == 0) ? HEARTBEAT[39 -: 8] : 8'($urandom),
                   4'($urandom));
        end
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items under the reset register values.
    put_item(rlfs_pkg::OP_BYTE, 8'h00, 4'hF);
    put_item(rlfs_pkg::OP_BYTE, 8'hFF, 4'h0);
    put_item(rlfs_pkg::OP_TICK, 8'hFF, 4'h0);
    put_item(rlfs_pkg::OP_TICK, 8'h00, 4'hF);
    send_heartbeat(-1);
    put_item(rlfs_pkg::OP_TICK, 8'h52, 4'h0);
    // A second 'R' breaks the match and is not taken as a fresh start.
    put_item(rlfs_pkg::OP_BYTE, HEARTBEAT[39 -: 8], 4'h0);
    send_heartbeat(-1);
    send_heartbeat(-1);
    put_item(rlfs_pkg::OP_TICK, 8'h00, 4'hF);

    // Short timeout and runs so that switching and beeping happen often.
    set_config(8'd3, 8'd8, 8'd9, 8'd2, 8'd2);
    random_traffic(60);

    // Widest settings; both switches can fall in one tick. Unknown indexes are
    // written too and must leave everything alone.
    set_config(8'd255, 8'hFF, 8'h00, 8'd0, 8'd255);
    for (int k = int'(rlfs_pkg::REG_BEEP_PERIOD) + 1;
         k < 2 ** $bits(rlfs_pkg::reg_index_t); k++) begin
      write_reg(rlfs_pkg::reg_index_t'(k), 8'($urandom));
    end
    idle_pct = 88;
    random_traffic(50);
    drain();
    random_traffic(50);

    // A zero reload drops the link on the next tick; upper data bits are masked.
    set_config(8'd0, 8'hF0, 8'h0F, 8'd254, 8'd1);
    idle_pct  = 0;
    stall_pct = 88;
    random_traffic(60);

    set_config(8'($urandom_range(1, 8)), 8'($urandom_range(4, 12)) | 8'($urandom) << 4,
               8'($urandom_range(5, 13)), 8'($urandom_range(0, 4)),
               8'($urandom_range(1, 6)));
    idle_pct  = 10;
    stall_pct = 10;
    random_traffic(60);

    // A zero beep period fires only when the counter wraps, after many ticks
    // lost on the backup radio; good runs are impossible here.
    set_config(8'd1, 8'd15, 8'd15, 8'd0, 8'd0);
    send_heartbeat(-1);
    repeat (300) put_item(rlfs_pkg::OP_TICK, 8'($urandom), 4'($urandom));

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rlfs_pkg.sv
hw/rtl/radio_link_failover_supervisor.sv
sim/radio_link_failover_supervisor_checker.sv
sim/radio_link_failover_supervisor_tb.sv
